// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL that carries concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk, idle while arst_n is low.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check a property on every rising edge of clk, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/smt_pkg.sv
// Shared types and constants of the set membership table.
`timescale 1ns / 1ps

package smt_pkg;

	localparam int SLOTS_DEF = 128;
	localparam int VALUE_W   = 32;

	typedef enum logic [1:0] {
		KIND_LOOKUP = 2'd0,
		KIND_INSERT = 2'd1,
		KIND_REMOVE = 2'd2,
		KIND_CLEAR  = 2'd3
	} smt_kind_t;

	typedef struct packed {
		smt_kind_t                  kind;
		logic signed [VALUE_W-1:0]  value;
	} smt_item_t;

	typedef struct packed {
		logic was_member;
		logic insert_dropped;
	} smt_result_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;     // latch the accepted word, clear the scan flags
		logic rd_en;    // read both slot memories at the scan address
		logic init_wr;  // clear the valid mark at the scan address
		logic commit;   // finish the operation, write a pending insert
	} smt_cmd_t;

endpackage

// File: rtl/smt_datapath.sv
// Slot memories, match and free-slot search, and result flags.
`timescale 1ns / 1ps

module smt_datapath import smt_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  smt_cmd_t                  cmd,
	input  logic [$clog2(SLOTS)-1:0]  addr,
	input  smt_item_t                 item,
	output smt_result_t               result
);

	localparam int AW = $clog2(SLOTS);

	logic [VALUE_W-1:0] val_mem [SLOTS];
	logic               vld_mem [SLOTS];

	logic [VALUE_W-1:0] val_rd_s1;
	logic               vld_rd_s1;
	logic [AW-1:0]      addr_s1;
	logic               chk_s1;

	smt_kind_t          kind_q;
	logic [VALUE_W-1:0] value_q;
	logic               member_q;
	logic               free_found_q;
	logic [AW-1:0]      free_idx_q;

	logic               hit;
	logic               scan_clr;
	logic               ins_ok;
	logic               val_we;
	logic               vld_we;
	logic [AW-1:0]      vld_wa;

	assign hit      = chk_s1 && vld_rd_s1 && (val_rd_s1 == value_q);
	assign scan_clr = chk_s1 && ((kind_q == KIND_CLEAR) || ((kind_q == KIND_REMOVE) && hit));
	assign ins_ok   = (kind_q == KIND_INSERT) && !member_q && free_found_q;
	assign val_we   = cmd.commit && ins_ok;
	assign vld_we   = cmd.init_wr || scan_clr || val_we;
	assign vld_wa   = cmd.init_wr ? addr : (scan_clr ? addr_s1 : free_idx_q);

	// Value memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (val_we) begin
			val_mem[free_idx_q] <= value_q;
		end
		if (cmd.rd_en) begin
			val_rd_s1 <= val_mem[addr];
		end
	end

	// Valid memory: only a commit sets a mark, every other write clears one.
	always_ff @(posedge clk) begin
		if (vld_we) begin
			vld_mem[vld_wa] <= cmd.commit;
		end
		if (cmd.rd_en) begin
			vld_rd_s1 <= vld_mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chk_s1       <= 1'b0;
			member_q     <= 1'b0;
			free_found_q <= 1'b0;
		end else begin
			chk_s1 <= cmd.rd_en;
			if (cmd.load) begin
				member_q     <= 1'b0;
				free_found_q <= 1'b0;
			end else if (chk_s1) begin
				if (hit) begin
					member_q <= 1'b1;
				end
				if (!vld_rd_s1) begin
					free_found_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= addr;
		if (cmd.load) begin
			kind_q  <= item.kind;
			value_q <= item.value;
		end
		if (chk_s1 && !vld_rd_s1 && !free_found_q) begin
			free_idx_q <= addr_s1;
		end
	end

	assign result.was_member     = member_q;
	assign result.insert_dropped = (kind_q == KIND_INSERT) && !member_q && !free_found_q;

endmodule

// File: rtl/smt_controller.sv
// Sequencer for the clearing pass and the per-word slot scan.
`timescale 1ns / 1ps

module smt_controller import smt_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	output logic                      done,
	output smt_cmd_t                  cmd,
	output logic [$clog2(SLOTS)-1:0]  addr
);

	localparam int AW = $clog2(SLOTS);

	typedef enum logic [4:0] {
		ST_INIT  = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_SCAN  = 5'b00100,
		ST_DRAIN = 5'b01000,
		ST_DONE  = 5'b10000
	} smt_state_t;

	smt_state_t    state_q;
	logic [AW-1:0] addr_q;
	logic          last;

	assign last = (addr_q == AW'(SLOTS - 1));
	assign addr = addr_q;
	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_DONE);

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_INIT: cmd.init_wr = 1'b1;
			ST_IDLE: cmd.load    = start;
			ST_SCAN: cmd.rd_en   = 1'b1;
			ST_DONE: cmd.commit  = 1'b1;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			addr_q  <= '0;
		end else begin
			case (state_q)
				ST_INIT: begin
					addr_q <= last ? '0 : addr_q + 1'b1;
					if (last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					addr_q <= '0;
					if (start) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					addr_q <= last ? '0 : addr_q + 1'b1;
					if (last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: state_q <= ST_DONE;
				ST_DONE:  state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: rtl/set_membership_table.sv
// Top level of the set membership table: controller, datapath and checks.
`timescale 1ns / 1ps

// A set of up to SLOTS signed 32-bit values. Issue a word by raising start
// while busy is low; the word is taken at that edge. Each word is a lookup,
// insert, remove or clear all, and returns exactly one result, shown on
// result for one cycle with done high. The receiver cannot stall: sample
// result in the cycle done is high. The block scans both slot memories one
// slot per cycle through their single read port. The scan visits every slot,
// a drain state waits for the registered read of the last slot, and done is
// high in the done state that follows it. Busy drops in the cycle after done,
// and the next word can be taken at the end of that cycle; a new word is
// never taken before the last one is done. After reset the block runs a
// clearing pass over every valid mark with busy high. An insert of a new
// value takes the lowest-numbered free slot; when none is free it is
// dropped and insert_dropped is set.

`include "assert_macros.svh"

module set_membership_table import smt_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  smt_item_t   item,
	output logic        done,
	output smt_result_t result
);

	smt_cmd_t                 cmd;
	logic [$clog2(SLOTS)-1:0] addr;

	// Sequence the clearing pass, the scan and the final commit.
	smt_controller #(
		.SLOTS (SLOTS)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd),
		.addr   (addr)
	);

	// Hold the slots, compare each one as it streams out, track the flags.
	smt_datapath #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.addr   (addr),
		.item   (item),
		.result (result)
	);

	// A result only appears while a word is in flight.
	`ASSERT_CLK(a_done_busy, done |-> busy, "done outside a busy operation")
	// An accepted word keeps the block busy in the following cycle.
	`ASSERT_CLK(a_accept_busy, (start && !busy) |=> busy, "accepted word did not raise busy")
	// The strobe lasts one cycle and the block is free right after it.
	`ASSERT_CLK(a_done_pulse, done |=> (!done && !busy), "done strobe not a single cycle")
	// A dropped insert is always one of a non-member.
	`ASSERT_CLK(a_drop_member, done |-> !(result.was_member && result.insert_dropped),
		"insert dropped for a member")

endmodule
